// ===== hdl/pcil_pkg.sv =====
`timescale 1ns / 1ps

package pcil_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int CNT_W       = 9;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RANK  = 2'd1;
  localparam logic [1:0] OP_INDEX = 2'd2;

  // Sorted key: colour in the upper 24 bits, palette index in the low byte.
  typedef logic [31:0] entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] colour;
    logic [7:0]  idx;
    logic [7:0]  want;
  } query_t;

  // Accumulators that travel down the row of cells with a query.
  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic             found;
    logic [7:0]       frank;
    logic [7:0]       first_idx;
    logic [7:0]       want_idx;
    logic             want_hit;
  } token_t;

endpackage

// ===== hdl/pcil_cell.sv =====
`timescale 1ns / 1ps

module pcil_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            load_en,
  input  pcil_pkg::entry_t load_value,
  input  logic            left_gt,
  input  logic            left_valid,
  input  pcil_pkg::entry_t left_entry,
  input  pcil_pkg::query_t query,
  input  pcil_pkg::token_t tok_in,
  output logic            gt,
  output logic            valid,
  output pcil_pkg::entry_t entry,
  output pcil_pkg::token_t tok_out
);

  logic             take;
  logic             lt;
  logic             eq;
  pcil_pkg::token_t tok_next;

  assign gt   = valid && (entry > load_value);
  // A cell takes a new value when it holds a greater key, or when it is the
  // first empty cell of the row.
  assign take = load_en && (gt || (left_valid && !valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry <= left_gt ? left_entry : load_value;
    end
  end

  assign lt = entry[31:8] < query.colour;
  assign eq = entry[31:8] == query.colour;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.active && valid) begin
      if (lt) begin
        tok_next.start = tok_in.start + 1'b1;
      end
      if (eq) begin
        tok_next.count = tok_in.count + 1'b1;
        if (!tok_in.found && (entry[7:0] == query.idx)) begin
          tok_next.found = 1'b1;
          tok_next.frank = tok_in.count[7:0];
        end
        if (tok_in.count == '0) begin
          tok_next.first_idx = entry[7:0];
        end
        if (tok_in.count == {1'b0, query.want}) begin
          tok_next.want_idx = entry[7:0];
          tok_next.want_hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== hdl/palette_colour_inverse_lookup_core.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                            Handshake
// -------   -----                                            ---------
// command   operation, colour_blue/green/red, entry_index,   start high while busy low
//           wanted_rank
// result    run_start, run_count, found_rank, found_index,   done high for one cycle
//           load_rejected
//
// A load is written into the row of cells at the accepting edge unless the row is full;
// a load or an unused operation code has its result appear with done in the next cycle.
// A query walks one cell a cycle down the row of MAX_ENTRIES cells; its result is
// registered when its token leaves the last cell, and busy is high until then.
// A new item may be accepted in the cycle that done is high.
// Reset empties the table; the receiver cannot stall results.

module palette_colour_inverse_lookup_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [7:0] colour_blue,
  input  logic [7:0] colour_green,
  input  logic [7:0] colour_red,
  input  logic [7:0] entry_index,
  input  logic [7:0] wanted_rank,
  output logic       done,
  output logic [8:0] run_start,
  output logic [8:0] run_count,
  output logic [7:0] found_rank,
  output logic [7:0] found_index,
  output logic       load_rejected
);

  localparam int N = pcil_pkg::MAX_ENTRIES;

  logic             accept;
  logic             is_query;
  logic             full;
  logic             load_en;
  logic             inject;
  pcil_pkg::entry_t load_value;
  pcil_pkg::query_t query;
  pcil_pkg::token_t tok_last;

  logic             gt    [N];
  logic             valid [N];
  pcil_pkg::entry_t entry [N];
  pcil_pkg::token_t tok   [N+1];

  assign accept     = start && !busy;
  assign is_query   = (operation == pcil_pkg::OP_RANK) || (operation == pcil_pkg::OP_INDEX);
  assign full       = valid[N-1];
  assign load_en    = accept && (operation == pcil_pkg::OP_LOAD) && !full;
  assign load_value = {colour_red, colour_green, colour_blue, entry_index};

  always_comb begin
    tok[0]        = '0;
    tok[0].active = inject;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      pcil_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .load_en    (load_en),
        .load_value (load_value),
        .left_gt    (1'b0),
        .left_valid (1'b1),
        .left_entry (load_value),
        .query      (query),
        .tok_in     (tok[i]),
        .gt         (gt[i]),
        .valid      (valid[i]),
        .entry      (entry[i]),
        .tok_out    (tok[i+1])
      );
    end else begin : g_rest
      pcil_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .load_en    (load_en),
        .load_value (load_value),
        .left_gt    (gt[i-1]),
        .left_valid (valid[i-1]),
        .left_entry (entry[i-1]),
        .query      (query),
        .tok_in     (tok[i]),
        .gt         (gt[i]),
        .valid      (valid[i]),
        .entry      (entry[i]),
        .tok_out    (tok[i+1])
      );
    end
  end

  assign tok_last = tok[N];

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      query <= {operation, colour_red, colour_green, colour_blue, entry_index, wanted_rank};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      inject <= 1'b0;
      done   <= 1'b0;
    end else begin
      inject <= accept && is_query;
      if (accept && is_query) begin
        busy <= 1'b1;
      end else if (tok_last.active) begin
        busy <= 1'b0;
      end
      done <= (accept && !is_query) || tok_last.active;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_query) begin
      run_start     <= '0;
      run_count     <= '0;
      found_rank    <= '0;
      found_index   <= '0;
      load_rejected <= (operation == pcil_pkg::OP_LOAD) && full;
    end else if (tok_last.active) begin
      run_start     <= tok_last.start;
      run_count     <= tok_last.count;
      load_rejected <= 1'b0;
      found_rank    <= ((query.op == pcil_pkg::OP_RANK) && tok_last.found) ?
                       tok_last.frank : 8'd0;
      if ((query.op == pcil_pkg::OP_INDEX) && (tok_last.count != '0)) begin
        // A wanted rank beyond the run falls back to the first entry.
        found_index <= tok_last.want_hit ? tok_last.want_idx : tok_last.first_idx;
      end else begin
        found_index <= '0;
      end
    end
  end

endmodule
